// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define SME_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// next-cycle implication, disabled while reset is active
`define SME_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

// File: sv/sme_pkg.sv
// types and constants of the stack machine execute unit
`default_nettype none
package sme_pkg;

	typedef enum logic [4:0] {
		OP_LOAD  = 5'd0,
		OP_IMM   = 5'd1,
		OP_STORE = 5'd2,
		OP_POP   = 5'd3,
		OP_ADD   = 5'd4,
		OP_SUB   = 5'd5,
		OP_MUL   = 5'd6,
		OP_DIV   = 5'd7,
		OP_JMP   = 5'd8,
		OP_JZ    = 5'd9,
		OP_EQ    = 5'd10,
		OP_NE    = 5'd11,
		OP_GT    = 5'd12,
		OP_LT    = 5'd13,
		OP_GE    = 5'd14,
		OP_LE    = 5'd15,
		OP_AND   = 5'd16,
		OP_OR    = 5'd17,
		OP_NOT   = 5'd18,
		OP_IN    = 5'd19,
		OP_OUT   = 5'd20,
		OP_LABEL = 5'd21
	} op_t;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UNDER = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_DIV0  = 3'd3;
	localparam logic [2:0] ST_ADDR  = 3'd4;

	typedef struct packed {
		logic [4:0]         req_type;
		logic signed [31:0] operand;
		logic signed [31:0] in_value;
		logic [11:0]        label_address;
	} req_t;

	typedef struct packed {
		logic [11:0]        next_pc;
		logic               out_valid;
		logic signed [31:0] out_value;
		logic [2:0]         status;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_DIV
	} state_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic clear;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_div;
		logic div_have;
		logic div_done;
		logic slot_free;
	} sts_t;

endpackage
`default_nettype wire

// File: sv/sme_div.sv
// iterative unsigned 32-bit divider, one quotient bit per cycle
`default_nettype none
module sme_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	import sme_pkg::*;

	localparam int STEPS = 32;
	localparam int SCW = $clog2(STEPS);

	logic [SCW-1:0] step_q;
	logic           busy_q;
	logic           done_q;
	logic [31:0]    quo_q;
	logic [31:0]    rem_q;
	logic [31:0]    dsr_q;
	logic [32:0]    rem_sh;
	logic [32:0]    rem_sub;

	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SCW'(1);
				if (step_q == SCW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!rem_sub[32]) begin
				rem_q <= rem_sub[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// File: sv/sme_datapath.sv
// datapath: stack, data memory, label table, program counter and result register
`default_nettype none
module sme_datapath #(
	parameter int STACK_DEPTH   = 64,
	parameter int DATA_WORDS    = 1024,
	parameter int LABEL_COUNT   = 128,
	parameter int PROGRAM_WORDS = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sme_pkg::req_t req,
	input  wire sme_pkg::cmd_t cmd,
	output sme_pkg::sts_t      sts,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output sme_pkg::rsp_t      rsp
);
	import sme_pkg::*;

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int DAW = $clog2(DATA_WORDS);
	localparam int LAW = $clog2(LABEL_COUNT);
	localparam int PCW = $clog2(PROGRAM_WORDS);
	localparam int CLR_WORDS = (DATA_WORDS > LABEL_COUNT) ? DATA_WORDS : LABEL_COUNT;
	localparam int CLW = $clog2(CLR_WORDS);

	logic [31:0]    stack_mem [STACK_DEPTH];
	logic [31:0]    data_mem  [DATA_WORDS];
	logic [PCW-1:0] lbl_mem   [LABEL_COUNT];

	req_t           req_q;
	logic [SCW-1:0] count_q;
	logic [PCW-1:0] pc_q;
	logic [CLW-1:0] clr_q;
	logic [31:0]    tos_q;
	logic [31:0]    nos_q;
	logic [31:0]    dmem_q;
	logic [PCW-1:0] lbl_q;
	logic           div_have_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	logic [SCW-1:0] cnt_m1;
	logic [SCW-1:0] cnt_m2;
	logic [31:0]    rd_opnd;
	logic           div_done;
	logic [31:0]    div_quo;
	logic [31:0]    div_dnd;
	logic [31:0]    div_dsr;

	// decoded instruction effects
	op_t            op;
	logic [31:0]    a;
	logic [31:0]    b;
	logic [31:0]    a_mag;
	logic [31:0]    b_mag;
	logic [31:0]    q_fix;
	logic [31:0]    bin_res;
	logic           full;
	logic           has1;
	logic           has2;
	logic           dok;
	logic           lok;
	logic           two_word;
	logic [PCW:0]   pc_inc;
	logic [PCW-1:0] pc_seq;
	logic [PCW-1:0] nxt_pc;
	logic [2:0]     st;
	logic [SCW-1:0] cnt_nxt;
	logic           stk_we;
	logic [SCW-1:0] stk_waddr;
	logic [31:0]    stk_wdata;
	logic           dm_we;
	logic           lb_we;
	logic           o_valid;
	logic [31:0]    o_value;
	logic           need_div;

	// label position modulo the program size by constant compare and subtract steps
	function automatic logic [PCW-1:0] pc_wrap(input logic [11:0] x);
		logic [12:0] r;
		r = {1'b0, x};
		for (int k = 11; k >= 0; k--) begin
			if ((PROGRAM_WORDS << k) < 4096) begin
				if (r >= 13'(PROGRAM_WORDS << k)) begin
					r = r - 13'(PROGRAM_WORDS << k);
				end
			end
		end
		return PCW'(r);
	endfunction

	assign cnt_m1  = count_q - SCW'(1);
	assign cnt_m2  = count_q - SCW'(2);
	assign rd_opnd = cmd.accept ? req.operand : req_q.operand;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
	end

	// memories: registered reads every cycle, one write per cycle each
	always_ff @(posedge clk) begin
		tos_q  <= stack_mem[cnt_m1[SAW-1:0]];
		nos_q  <= stack_mem[cnt_m2[SAW-1:0]];
		dmem_q <= data_mem[rd_opnd[DAW-1:0]];
		lbl_q  <= lbl_mem[rd_opnd[LAW-1:0]];
		if (cmd.commit && stk_we) begin
			stack_mem[stk_waddr[SAW-1:0]] <= stk_wdata;
		end
		if (cmd.clear) begin
			if ({1'b0, clr_q} < (CLW + 1)'(DATA_WORDS)) begin
				data_mem[clr_q[DAW-1:0]] <= '0;
			end
			if ({1'b0, clr_q} < (CLW + 1)'(LABEL_COUNT)) begin
				lbl_mem[clr_q[LAW-1:0]] <= '0;
			end
		end else if (cmd.commit) begin
			if (dm_we) begin
				data_mem[req_q.operand[DAW-1:0]] <= b;
			end
			if (lb_we) begin
				lbl_mem[req_q.operand[LAW-1:0]] <= pc_wrap(req_q.label_address);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pc_q        <= '0;
			clr_q       <= '0;
			div_have_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (cmd.accept) begin
				div_have_q <= 1'b0;
			end else if (div_done) begin
				div_have_q <= 1'b1;
			end
			if (cmd.commit) begin
				count_q     <= cnt_nxt;
				pc_q        <= nxt_pc;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.next_pc   <= 12'(nxt_pc);
			rsp_q.out_valid <= o_valid;
			rsp_q.out_value <= o_value;
			rsp_q.status    <= st;
		end
	end

	// divide on magnitudes, quotient sign fixed afterwards
	assign a     = nos_q;
	assign b     = tos_q;
	assign a_mag = a[31] ? (32'd0 - a) : a;
	assign b_mag = b[31] ? (32'd0 - b) : b;
	assign q_fix = (a[31] ^ b[31]) ? (32'd0 - div_quo) : div_quo;
	assign div_dnd = a_mag;
	assign div_dsr = b_mag;

	sme_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dnd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo)
	);

	always_comb begin
		op       = op_t'(req_q.req_type);
		full     = (count_q == SCW'(STACK_DEPTH));
		has1     = (count_q != '0);
		has2     = (count_q >= SCW'(2));
		dok      = !req_q.operand[31] && (req_q.operand < 32'(DATA_WORDS));
		lok      = !req_q.operand[31] && (req_q.operand < 32'(LABEL_COUNT));
		two_word = (op == OP_LOAD) || (op == OP_IMM) || (op == OP_STORE) ||
			(op == OP_JMP) || (op == OP_JZ);
		pc_inc   = {1'b0, pc_q} + (two_word ? (PCW + 1)'(2) : (PCW + 1)'(1));
		if (pc_inc >= (PCW + 1)'(PROGRAM_WORDS)) begin
			pc_inc = pc_inc - (PCW + 1)'(PROGRAM_WORDS);
		end
		pc_seq   = pc_inc[PCW-1:0];

		unique case (op)
			OP_ADD:  bin_res = a + b;
			OP_SUB:  bin_res = a - b;
			OP_MUL:  bin_res = a * b;
			OP_DIV:  bin_res = q_fix;
			OP_EQ:   bin_res = 32'(a == b);
			OP_NE:   bin_res = 32'(a != b);
			OP_GT:   bin_res = 32'($signed(b) < $signed(a));
			OP_LT:   bin_res = 32'($signed(a) < $signed(b));
			OP_GE:   bin_res = 32'(!($signed(a) < $signed(b)));
			OP_LE:   bin_res = 32'(!($signed(b) < $signed(a)));
			OP_AND:  bin_res = 32'((a != '0) && (b != '0));
			default: bin_res = 32'((a != '0) || (b != '0));
		endcase

		st        = ST_OK;
		nxt_pc    = pc_seq;
		cnt_nxt   = count_q;
		stk_we    = 1'b0;
		stk_waddr = count_q;
		stk_wdata = bin_res;
		dm_we     = 1'b0;
		lb_we     = 1'b0;
		o_valid   = 1'b0;
		o_value   = '0;
		need_div  = 1'b0;

		unique case (op)
			OP_LOAD, OP_IMM, OP_IN: begin
				if (full) begin
					st = ST_OVER;
				end else if (op == OP_LOAD && !dok) begin
					st = ST_ADDR;
				end else begin
					stk_we    = 1'b1;
					stk_waddr = count_q;
					stk_wdata = (op == OP_LOAD) ? dmem_q :
						((op == OP_IMM) ? req_q.operand : req_q.in_value);
					cnt_nxt   = count_q + SCW'(1);
				end
			end
			OP_STORE: begin
				if (!has1) begin
					st = ST_UNDER;
				end else if (!dok) begin
					st = ST_ADDR;
				end else begin
					dm_we = 1'b1;
				end
			end
			OP_POP, OP_NOT, OP_OUT: begin
				if (!has1) begin
					st = ST_UNDER;
				end else if (op == OP_NOT) begin
					stk_we    = 1'b1;
					stk_waddr = cnt_m1;
					stk_wdata = 32'(b == '0);
				end else begin
					cnt_nxt = cnt_m1;
					if (op == OP_OUT) begin
						o_valid = 1'b1;
						o_value = b;
					end
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_GT, OP_LT,
			OP_GE, OP_LE, OP_AND, OP_OR: begin
				if (!has2) begin
					st = ST_UNDER;
				end else if (op == OP_DIV && b == '0) begin
					st = ST_DIV0;
				end else begin
					need_div  = (op == OP_DIV);
					stk_we    = 1'b1;
					stk_waddr = cnt_m2;
					cnt_nxt   = cnt_m1;
				end
			end
			OP_JMP: begin
				if (!lok) begin
					st = ST_ADDR;
				end else begin
					nxt_pc = lbl_q;
				end
			end
			OP_JZ: begin
				if (!has1) begin
					st = ST_UNDER;
				end else if (!lok) begin
					st = ST_ADDR;
				end else begin
					cnt_nxt = cnt_m1;
					if (b == '0) begin
						nxt_pc = lbl_q;
					end
				end
			end
			OP_LABEL: begin
				nxt_pc = pc_q;
				if (!lok) begin
					st = ST_ADDR;
				end else begin
					lb_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.clear_done = (clr_q == CLW'(CLR_WORDS - 1));
	assign sts.need_div   = need_div;
	assign sts.div_have   = div_have_q;
	assign sts.div_done   = div_done;
	assign sts.slot_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire

// File: sv/sme_ctrl.sv
// controller state machine: clearing pass, accept, execute, divide wait
`default_nettype none
module sme_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sme_pkg::sts_t sts,
	output sme_pkg::cmd_t      cmd
);
	import sme_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.need_div && !sts.div_have) begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV;
				end else if (sts.slot_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_nxt = S_EXEC;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end
endmodule
`default_nettype wire

// File: sv/stack_machine_execute_unit.sv
// Stack machine execute unit: one instruction word in, one result word out.
// Flow: memory reads are registered at the accepting edge, then the execute step registers the result word.
// Words: a new word is taken only after the last one has committed; div also waits for the bit-serial divider
// (one quotient bit per cycle); a stalled result word holds off the execute step.
// Reset: stack empty, pc zero; then a clearing pass over max(DATA_WORDS, LABEL_COUNT) words
// zeroes data memory and label table before the first word is taken.
`default_nettype none
module stack_machine_execute_unit #(
	parameter int STACK_DEPTH   = 64,
	parameter int DATA_WORDS    = 1024,
	parameter int LABEL_COUNT   = 128,
	parameter int PROGRAM_WORDS = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sme_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output sme_pkg::rsp_t      rsp
);
	import sme_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sme_datapath #(
		.STACK_DEPTH   (STACK_DEPTH),
		.DATA_WORDS    (DATA_WORDS),
		.LABEL_COUNT   (LABEL_COUNT),
		.PROGRAM_WORDS (PROGRAM_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

// File: sv/sme_checker.sv
// port-level checker for the stack machine execute unit, with its bind
`default_nettype none
`include "assert_macros.svh"
module sme_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire sme_pkg::rsp_t rsp
);
	import sme_pkg::*;

	// a held result word stays put
	`SME_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	// one word at a time: busy right after an accept
	`SME_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	// an output value only comes with ok status
	`SME_ASSERT_IMP(a_out_ok, clk, arst_n, rsp_valid && rsp.out_valid, rsp.status == ST_OK)
	// no popped value means a zero value field
	`SME_ASSERT_IMP(a_out_zero, clk, arst_n, rsp_valid && !rsp.out_valid, rsp.out_value == 0)
	`SME_ASSERT_IMP(a_status_code, clk, arst_n, rsp_valid,
		rsp.status == ST_OK || rsp.status == ST_UNDER || rsp.status == ST_OVER ||
		rsp.status == ST_DIV0 || rsp.status == ST_ADDR)
endmodule

bind stack_machine_execute_unit sme_checker u_sme_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
